// File: rtl/ett_pkg.sv
`default_nettype none

package ett_pkg;

  localparam int unsigned POS_W = 16;
  localparam int unsigned OFS_W = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_FF     = 8'hFF;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef enum logic [2:0] {
    MODE_OUT     = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_STR     = 3'd2,
    MODE_QUOTE   = 3'd3,
    MODE_SLASH   = 3'd4
  } scan_mode_e;

  typedef enum logic [2:0] {
    KIND_OPEN   = 3'd0,
    KIND_CLOSE  = 3'd1,
    KIND_STR    = 3'd2,
    KIND_EOT    = 3'd3,
    KIND_UNTERM = 3'd4
  } token_kind_e;

  typedef struct packed {
    logic             valid;
    token_kind_e      kind;
    logic [OFS_W-1:0] str_start;
    logic [OFS_W-1:0] str_end;
  } token_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

`default_nettype wire

// File: rtl/ett_scan.sv
`default_nettype none

module ett_scan import ett_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output token_t          token_o
);

  scan_mode_e       mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] begin_q, begin_d;
  logic [POS_W-1:0] cand_q, cand_d;
  logic [POS_W-1:0] pos_inc;
  token_t           tok;

  assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

  always_comb begin
    mode_d        = mode_q;
    pos_d         = pos_inc;
    begin_d       = begin_q;
    cand_d        = cand_q;
    tok.valid     = 1'b0;
    tok.kind      = KIND_OPEN;
    tok.str_start = '0;
    tok.str_end   = '0;
    unique case (mode_q)
      MODE_COMMENT: begin
        if (byte_i == CH_NUL || byte_i == CH_FF) begin
          mode_d    = MODE_OUT;
          pos_d     = '0;
          tok.valid = 1'b1;
          tok.kind  = KIND_EOT;
        end else if (byte_i == CH_LF || byte_i == CH_CR) begin
          mode_d = MODE_OUT;
        end
      end
      MODE_STR, MODE_QUOTE, MODE_SLASH: begin
        if (byte_i == CH_NUL) begin
          mode_d    = MODE_OUT;
          pos_d     = '0;
          tok.valid = 1'b1;
          tok.kind  = KIND_UNTERM;
        end else if (byte_i == CH_QUOTE) begin
          cand_d = pos_q;
          mode_d = MODE_QUOTE;
        end else if (mode_q == MODE_QUOTE) begin
          if (is_ws(byte_i)) begin
            mode_d        = MODE_OUT;
            tok.valid     = 1'b1;
            tok.kind      = KIND_STR;
            tok.str_start = OFS_W'(begin_q);
            tok.str_end   = OFS_W'(cand_q);
          end else if (byte_i == CH_SLASH) begin
            mode_d = MODE_SLASH;
          end else begin
            mode_d = MODE_STR;
          end
        end else if (mode_q == MODE_SLASH) begin
          if (byte_i == CH_SLASH) begin
            mode_d        = MODE_COMMENT;
            tok.valid     = 1'b1;
            tok.kind      = KIND_STR;
            tok.str_start = OFS_W'(begin_q);
            tok.str_end   = OFS_W'(cand_q);
          end else begin
            mode_d = MODE_STR;
          end
        end
      end
      default: begin
        mode_d = MODE_OUT;
        if (byte_i == CH_NUL || byte_i == CH_FF) begin
          pos_d     = '0;
          tok.valid = 1'b1;
          tok.kind  = KIND_EOT;
        end else if (byte_i == CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else if (byte_i == CH_LBRACE || byte_i == CH_LPAREN) begin
          tok.valid = 1'b1;
          tok.kind  = KIND_OPEN;
        end else if (byte_i == CH_RBRACE || byte_i == CH_RPAREN) begin
          tok.valid = 1'b1;
          tok.kind  = KIND_CLOSE;
        end else if (byte_i == CH_QUOTE) begin
          begin_d = pos_inc;
          mode_d  = MODE_STR;
        end
      end
    endcase
  end

  assign token_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OUT;
      pos_q   <= '0;
      begin_q <= '0;
      cand_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      cand_q  <= cand_d;
    end
  end

  a_end_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tok.valid && (tok.kind == KIND_EOT || tok.kind == KIND_UNTERM)
    |=> pos_q == '0)
    else $error("position not cleared at end of text");

  a_str_leaves_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tok.valid && tok.kind == KIND_STR
    |=> mode_q == MODE_OUT || mode_q == MODE_COMMENT)
    else $error("string token left scanner inside string");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !(tok.valid && (tok.kind == KIND_EOT || tok.kind == KIND_UNTERM))
    |=> pos_q >= $past(pos_q))
    else $error("position went backwards");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q) && $stable(mode_q))
    else $error("scanner state moved without a byte");

endmodule

`default_nettype wire

// File: rtl/entity_text_tokenizer.sv
// Entity text tokenizer.
// Input channel: one text byte per transfer on text_valid_i / text_byte_i,
// held back by text_stall_o. NUL or 0xFF outside a string ends the text.
// Output channel: token_valid_o with token_kind_o, str_start_o, str_end_o,
// held back by token_stall_i. A byte yields at most one token; bytes that
// yield none are consumed silently.
// A taken byte goes through the input register, then through the scan logic
// into the output register, which presents its token.
// Throughput: one byte per cycle unless the output stalls; scan state updates per byte.
// When token_stall_i is high with a token waiting, the waiting byte is held
// in the input register and text_stall_o rises once that register is full.
// Reset clears both registers' valid flags, the scan mode (outside any token)
// and all offsets to zero.
// Offsets saturate at the top of the position counter.
`default_nettype none

module entity_text_tokenizer import ett_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             text_valid_i,
  output logic                  text_stall_o,
  input  wire logic [7:0]       text_byte_i,
  output logic                  token_valid_o,
  input  wire logic             token_stall_i,
  output logic [2:0]            token_kind_o,
  output logic [OFS_W-1:0]      str_start_o,
  output logic [OFS_W-1:0]      str_end_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_ready;
  logic       step;
  logic       in_take;
  token_t     tok;
  token_t     out_q;

  assign out_ready    = !out_q.valid || !token_stall_i;
  assign step         = in_valid_q && out_ready;
  assign text_stall_o = in_valid_q && !out_ready;
  assign in_take      = text_valid_i && !text_stall_o;

  ett_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .token_o (tok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || step) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= text_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (out_ready) begin
      out_q.valid <= step && tok.valid;
      if (step && tok.valid) begin
        out_q.kind      <= tok.kind;
        out_q.str_start <= tok.str_start;
        out_q.str_end   <= tok.str_end;
      end
    end
  end

  assign token_valid_o = out_q.valid;
  assign token_kind_o  = out_q.kind;
  assign str_start_o   = out_q.str_start;
  assign str_end_o     = out_q.str_end;

  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_ready |=> in_valid_q && $stable(in_byte_q))
    else $error("held byte lost while output stalled");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_stall_o |-> in_valid_q && out_q.valid)
    else $error("input stalled with room to spare");

  a_token_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(token_valid_o) |-> $past(step) && $past(tok.valid))
    else $error("token appeared without a scanned byte");

endmodule

`default_nettype wire
